/* rtl/w2u_pkg.sv */
package w2u_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam logic [15:0] CAP_RESET = 16'hFFFF;

    // stop status codes
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_NUL  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_EOI  = 2'd3;

    // item function codes
    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    localparam logic [7:0] LEAD_C2   = 8'hC2;
    localparam logic [7:0] LEAD_C3   = 8'hC3;
    localparam logic [7:0] CONT_BASE = 8'h80;
    localparam logic [7:0] CONT_MASK = 8'h3F;
    localparam logic [7:0] QMARK     = 8'h3F;

    typedef struct packed {
        logic [1:0]      len;
        logic [2:0][7:0] b;     // b[0] goes out first
    } t_seq;

    // one queued conversion result group
    typedef struct packed {
        logic [2:0][7:0] b;
        logic [1:0]      n;
        logic            vld;
        logic [1:0]      status;
        logic [15:0]     consumed;
        logic [15:0]     written;
    } t_job;

    function automatic t_seq mk(input logic [1:0] len, input logic [7:0] b0,
                                input logic [7:0] b1, input logic [7:0] b2);
        t_seq s;
        s.len = len;
        s.b[0] = b0;
        s.b[1] = b1;
        s.b[2] = b2;
        return s;
    endfunction

    // 0x80-0x9F control block
    function automatic t_seq ctl_rom(input logic [4:0] idx);
        t_seq s;
        unique case (idx)
            5'd0:  s = mk(2'd3, 8'hE2, 8'h82, 8'hAC);
            5'd1:  s = mk(2'd1, QMARK, 8'h00, 8'h00);
            5'd2:  s = mk(2'd3, 8'hE2, 8'h80, 8'h9A);
            5'd3:  s = mk(2'd2, 8'hC6, 8'h92, 8'h00);
            5'd4:  s = mk(2'd3, 8'hE2, 8'h80, 8'h9E);
            5'd5:  s = mk(2'd3, 8'hE2, 8'h80, 8'hA6);
            5'd6:  s = mk(2'd3, 8'hE2, 8'h80, 8'hA0);
            5'd7:  s = mk(2'd3, 8'hE2, 8'h80, 8'hA1);
            5'd8:  s = mk(2'd2, 8'hCB, 8'h86, 8'h00);
            5'd9:  s = mk(2'd3, 8'hE2, 8'h80, 8'hB0);
            5'd10: s = mk(2'd2, 8'hC5, 8'hA0, 8'h00);
            5'd11: s = mk(2'd3, 8'hE2, 8'h80, 8'hB9);
            5'd12: s = mk(2'd2, 8'hC5, 8'h92, 8'h00);
            5'd13: s = mk(2'd1, QMARK, 8'h00, 8'h00);
            5'd14: s = mk(2'd2, 8'hC5, 8'hBD, 8'h00);
            5'd15: s = mk(2'd1, QMARK, 8'h00, 8'h00);
            5'd16: s = mk(2'd1, QMARK, 8'h00, 8'h00);
            5'd17: s = mk(2'd3, 8'hE2, 8'h80, 8'h98);
            5'd18: s = mk(2'd3, 8'hE2, 8'h80, 8'h99);
            5'd19: s = mk(2'd3, 8'hE2, 8'h80, 8'h9C);
            5'd20: s = mk(2'd3, 8'hE2, 8'h80, 8'h9D);
            5'd21: s = mk(2'd3, 8'hE2, 8'h80, 8'hA2);
            5'd22: s = mk(2'd3, 8'hE2, 8'h80, 8'h93);
            5'd23: s = mk(2'd3, 8'hE2, 8'h80, 8'h94);
            5'd24: s = mk(2'd2, 8'hCB, 8'h9C, 8'h00);
            5'd25: s = mk(2'd3, 8'hE2, 8'h84, 8'hA2);
            5'd26: s = mk(2'd2, 8'hC5, 8'hA1, 8'h00);
            5'd27: s = mk(2'd3, 8'hE2, 8'h80, 8'hBA);
            5'd28: s = mk(2'd2, 8'hC5, 8'h93, 8'h00);
            5'd29: s = mk(2'd1, QMARK, 8'h00, 8'h00);
            5'd30: s = mk(2'd2, 8'hC5, 8'hBE, 8'h00);
            5'd31: s = mk(2'd2, 8'hC5, 8'hB8, 8'h00);
            default: s = mk(2'd1, QMARK, 8'h00, 8'h00);
        endcase
        return s;
    endfunction

endpackage

/* rtl/w2u_intf.sv */
interface w2u_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] in_byte;

    modport source (output valid, output func, output in_byte, input ready);
    modport sink   (input valid, input func, input in_byte, output ready);
endinterface

interface w2u_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [1:0]  status;
    logic [15:0] consumed_count;
    logic [15:0] written_count;

    modport source (output valid, output out_byte, output byte_valid, output last,
                    output status, output consumed_count, output written_count,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input last,
                    input status, input consumed_count, input written_count,
                    output ready);
endinterface

interface w2u_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/w2u_in_reg.sv */
module w2u_in_reg (
    input  logic     i_clk,
    input  logic     i_rst_n,
    w2u_in_if.sink   i_in,
    input  logic     i_consume,
    output logic     o_valid,
    output logic     o_func,
    output logic [7:0] o_byte
);

    logic       r_v;
    logic       r_func;
    logic [7:0] r_byte;

    assign i_in.ready = !r_v || i_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_in.ready) begin
            r_v <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_func <= i_in.func;
            r_byte <= i_in.in_byte;
        end
    end

    assign o_valid = r_v;
    assign o_func  = r_func;
    assign o_byte  = r_byte;

endmodule

/* rtl/w2u_xlate.sv */
module w2u_xlate #(
    parameter int COUNT_WIDTH = w2u_pkg::COUNT_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    w2u_cfg_if.sink       i_cfg,
    input  logic          i_item_v,
    input  logic          i_func,
    input  logic [7:0]    i_byte,
    input  logic          i_take,
    output logic          o_consume,
    output logic          o_load,
    output w2u_pkg::t_job o_job
);

    localparam int CMPW = (COUNT_WIDTH + 2 > 17) ? COUNT_WIDTH + 2 : 17;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [15:0]            r_cap;
    logic [COUNT_WIDTH-1:0] r_written;
    logic [COUNT_WIDTH-1:0] r_consumed;
    logic [1:0]             r_stopped;

    logic [COUNT_WIDTH-1:0] n_written;
    logic [COUNT_WIDTH-1:0] n_consumed;
    logic [1:0]             n_stopped;

    w2u_pkg::t_seq      seq;
    logic [1:0]         need;
    logic [CMPW-1:0]    wr_ext;
    logic [CMPW-1:0]    cap_ext;
    logic               fits;
    logic               room;
    logic [COUNT_WIDTH:0] wr_sum;
    logic [COUNT_WIDTH:0] cn_sum;
    logic [CMPW-1:0]    wr_rep;
    logic [CMPW-1:0]    cn_rep;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        if ((i_byte & 8'hC0) == 8'hC0) begin
            seq = w2u_pkg::mk(2'd2, w2u_pkg::LEAD_C3,
                              w2u_pkg::CONT_BASE | (i_byte & w2u_pkg::CONT_MASK), 8'h00);
            need = 2'd2;
        end else if ((i_byte & 8'hA0) == 8'hA0) begin
            seq = w2u_pkg::mk(2'd2, w2u_pkg::LEAD_C2,
                              w2u_pkg::CONT_BASE | (i_byte & w2u_pkg::CONT_MASK), 8'h00);
            need = 2'd2;
        end else if (i_byte[7]) begin
            seq  = w2u_pkg::ctl_rom(i_byte[4:0]);
            need = 2'd3;    // ROM codes always reserve three bytes
        end else begin
            seq  = w2u_pkg::mk(2'd1, i_byte, 8'h00, 8'h00);
            need = 2'd1;
        end
    end

    assign wr_ext  = CMPW'(r_written);
    assign cap_ext = CMPW'(r_cap);
    assign fits    = (wr_ext + CMPW'(need)) < cap_ext;
    assign room    = wr_ext < cap_ext;

    assign wr_sum = {1'b0, r_written} + (COUNT_WIDTH+1)'(seq.len);
    assign cn_sum = {1'b0, r_consumed} + (COUNT_WIDTH+1)'(1);

    assign o_consume = i_item_v && ((r_stopped != w2u_pkg::ST_RUN) || i_take);
    assign o_load    = i_item_v && (r_stopped == w2u_pkg::ST_RUN) && i_take;

    always_comb begin
        n_written  = r_written;
        n_consumed = r_consumed;
        n_stopped  = r_stopped;
        priority if (i_func == w2u_pkg::FUNC_END) begin
            n_stopped = w2u_pkg::ST_EOI;
        end else if (i_byte == 8'h00) begin
            n_stopped = w2u_pkg::ST_NUL;
        end else if (!fits) begin
            n_stopped = w2u_pkg::ST_FULL;
        end else begin
            n_written  = wr_sum[COUNT_WIDTH] ? CNT_MAX : wr_sum[COUNT_WIDTH-1:0];
            n_consumed = cn_sum[COUNT_WIDTH] ? CNT_MAX : cn_sum[COUNT_WIDTH-1:0];
        end
    end

    assign wr_rep = CMPW'(n_written);
    assign cn_rep = CMPW'(n_consumed);

    always_comb begin
        o_job.consumed = cn_rep[15:0];
        o_job.written  = wr_rep[15:0];
        o_job.status   = n_stopped;
        if (n_stopped != w2u_pkg::ST_RUN) begin
            // terminator, or an empty stop result when no byte is left
            o_job.b   = '0;
            o_job.n   = 2'd1;
            o_job.vld = room;
        end else begin
            o_job.b   = seq.b;
            o_job.n   = seq.len;
            o_job.vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= w2u_pkg::CAP_RESET;
            r_written  <= '0;
            r_consumed <= '0;
            r_stopped  <= w2u_pkg::ST_RUN;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.data;
            end
            if (o_load) begin
                r_written  <= n_written;
                r_consumed <= n_consumed;
                r_stopped  <= n_stopped;
            end
        end
    end

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped != w2u_pkg::ST_RUN |=> r_stopped == $past(r_stopped))
        else $error("stop status changed after a stop");

    a_stop_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load && o_job.status != w2u_pkg::ST_RUN |=>
            r_written == $past(r_written) && r_consumed == $past(r_consumed))
        else $error("counters moved on a stop");

endmodule

/* rtl/w2u_emit.sv */
module w2u_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  w2u_pkg::t_job i_job,
    output logic          o_take,
    w2u_out_if.source     o_out
);

    logic          r_v;
    logic [1:0]    r_idx;
    w2u_pkg::t_job r_job;
    logic          is_last;
    logic          fire;

    assign is_last = (2'(r_idx + 2'd1) == r_job.n);
    assign fire    = r_v && o_out.ready;
    assign o_take  = !r_v || (fire && is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_idx <= '0;
        end else if (i_load) begin
            r_v   <= 1'b1;
            r_idx <= '0;
        end else if (fire) begin
            if (is_last) begin
                r_v <= 1'b0;
            end else begin
                r_idx <= 2'(r_idx + 2'd1);
            end
        end
        if (i_load) begin
            r_job <= i_job;
        end
    end

    assign o_out.valid          = r_v;
    assign o_out.out_byte       = r_job.b[r_idx];
    assign o_out.byte_valid     = r_job.vld;
    assign o_out.last           = is_last;
    assign o_out.status         = r_job.status;
    assign o_out.consumed_count = r_job.consumed;
    assign o_out.written_count  = r_job.written;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v |-> r_idx < r_job.n)
        else $error("byte index past sequence length");

    a_stop_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && r_job.status != w2u_pkg::ST_RUN |-> r_job.n == 2'd1 && r_job.b[0] == 8'h00)
        else $error("stop result is not a single zero byte");

    a_novld_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && !r_job.vld |-> is_last && r_job.status != w2u_pkg::ST_RUN)
        else $error("empty result outside a stop");

endmodule

/* rtl/win1252_to_utf8_encoder.sv */
// Windows-1252 to UTF-8 converter.
// i_in carries one item per transaction: func (data byte or end of input) and
// in_byte. o_out carries one UTF-8 byte per transaction with byte_valid, last,
// status and the consumed/written counts after the item. i_cfg writes the
// output capacity (terminator included); write it only while the block is idle.
// An accepted item passes the input register and then the job register on its way
// to the output. Throughput follows the output byte rate: the job register feeds
// one byte per cycle while the receiver is ready, and ASCII gives 1 byte per item,
// 0xA0-0xFF give 2, and 0x80-0x9F give 1 to 3 depending on the sequence length.
// A NUL byte, end of input or lack of room ends the string with one result
// (the 0x00 terminator when a byte is free); later items are taken and dropped.
// Reset clears the counters and the stop status and sets capacity to 65535;
// there is no clearing pass.
// When the receiver stalls, the current byte holds; one more item waits in the
// input register, then i_in.ready drops.
module win1252_to_utf8_encoder #(
    parameter int COUNT_WIDTH = w2u_pkg::COUNT_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    w2u_in_if.sink    i_in,
    w2u_cfg_if.sink   i_cfg,
    w2u_out_if.source o_out
);

    logic          item_v;
    logic          item_func;
    logic [7:0]    item_byte;
    logic          consume;
    logic          load;
    logic          take;
    w2u_pkg::t_job job;

    w2u_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_consume (consume),
        .o_valid   (item_v),
        .o_func    (item_func),
        .o_byte    (item_byte)
    );

    w2u_xlate #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_xlate (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_item_v  (item_v),
        .i_func    (item_func),
        .i_byte    (item_byte),
        .i_take    (take),
        .o_consume (consume),
        .o_load    (load),
        .o_job     (job)
    );

    w2u_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_job   (job),
        .o_take  (take),
        .o_out   (o_out)
    );

endmodule

/* sim/win1252_to_utf8_encoder_test.sv */
`timescale 1ns / 1ps

module win1252_to_utf8_encoder_test;

    localparam int COUNT_MAX   = (1 << w2u_pkg::COUNT_WIDTH_DEF) - 1;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 500000;
    localparam int N_DIRECTED  = 22;

    // one UTF-8 output byte with the status and counts that come with it
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last;
        logic [1:0]  status;
        logic [15:0] consumed;
        logic [15:0] written;
    } t_utf8_res;

    // directed row: n_typed != 0 means the UTF-8 bytes are given right here
    typedef struct packed {
        logic        func;
        logic [7:0]  in_byte;
        logic [1:0]  n_typed;
        logic [23:0] typed;
    } t_stim_row;

    // 0x80-0x9F block: {length, first byte, second byte, third byte}
    localparam logic [25:0] CP1252_CTL [32] = '{
        {2'd3, 24'hE282AC}, {2'd1, 24'h3F0000}, {2'd3, 24'hE2809A}, {2'd2, 24'hC69200},
        {2'd3, 24'hE2809E}, {2'd3, 24'hE280A6}, {2'd3, 24'hE280A0}, {2'd3, 24'hE280A1},
        {2'd2, 24'hCB8600}, {2'd3, 24'hE280B0}, {2'd2, 24'hC5A000}, {2'd3, 24'hE280B9},
        {2'd2, 24'hC59200}, {2'd1, 24'h3F0000}, {2'd2, 24'hC5BD00}, {2'd1, 24'h3F0000},
        {2'd1, 24'h3F0000}, {2'd3, 24'hE28098}, {2'd3, 24'hE28099}, {2'd3, 24'hE2809C},
        {2'd3, 24'hE2809D}, {2'd3, 24'hE280A2}, {2'd3, 24'hE28093}, {2'd3, 24'hE28094},
        {2'd2, 24'hCB9C00}, {2'd3, 24'hE284A2}, {2'd2, 24'hC5A100}, {2'd3, 24'hE280BA},
        {2'd2, 24'hC59300}, {2'd1, 24'h3F0000}, {2'd2, 24'hC5BE00}, {2'd2, 24'hC5B800}
    };

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{w2u_pkg::FUNC_DATA, 8'h41, 2'd1, 24'h410000},
        '{w2u_pkg::FUNC_DATA, 8'h01, 2'd1, 24'h010000},
        '{w2u_pkg::FUNC_DATA, 8'h7F, 2'd1, 24'h7F0000},
        '{w2u_pkg::FUNC_DATA, 8'h80, 2'd3, 24'hE282AC},  // euro sign
        '{w2u_pkg::FUNC_DATA, 8'h81, 2'd1, 24'h3F0000},  // undefined codes map to '?'
        '{w2u_pkg::FUNC_DATA, 8'h8D, 2'd1, 24'h3F0000},
        '{w2u_pkg::FUNC_DATA, 8'h8F, 2'd1, 24'h3F0000},
        '{w2u_pkg::FUNC_DATA, 8'h90, 2'd1, 24'h3F0000},
        '{w2u_pkg::FUNC_DATA, 8'h9D, 2'd1, 24'h3F0000},
        '{w2u_pkg::FUNC_DATA, 8'h83, 2'd0, 24'h000000},
        '{w2u_pkg::FUNC_DATA, 8'h9F, 2'd0, 24'h000000},
        '{w2u_pkg::FUNC_DATA, 8'h8A, 2'd0, 24'h000000},
        '{w2u_pkg::FUNC_DATA, 8'h99, 2'd0, 24'h000000},
        '{w2u_pkg::FUNC_DATA, 8'hA0, 2'd2, 24'hC2A000},
        '{w2u_pkg::FUNC_DATA, 8'hBF, 2'd2, 24'hC2BF00},
        '{w2u_pkg::FUNC_DATA, 8'hC0, 2'd2, 24'hC38000},
        '{w2u_pkg::FUNC_DATA, 8'hFF, 2'd2, 24'hC3BF00},
        '{w2u_pkg::FUNC_DATA, 8'hDF, 2'd0, 24'h000000},
        '{w2u_pkg::FUNC_DATA, 8'hE0, 2'd0, 24'h000000},
        '{w2u_pkg::FUNC_DATA, 8'h55, 2'd0, 24'h000000},
        '{w2u_pkg::FUNC_DATA, 8'hAA, 2'd0, 24'h000000},
        '{w2u_pkg::FUNC_DATA, 8'h20, 2'd0, 24'h000000}
    };

    logic clk = 1'b0;
    logic rst_n;

    w2u_in_if  in_ch ();
    w2u_cfg_if cfg_ch ();
    w2u_out_if out_ch ();

    win1252_to_utf8_encoder uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #4 clk = ~clk;

    // encoder state as seen from outside
    int         capacity    = int'(w2u_pkg::CAP_RESET);
    int         wr_count    = 0;
    int         rd_count    = 0;
    logic [1:0] stop_status = w2u_pkg::ST_RUN;

    t_utf8_res utf8_expect_q [$];
    int        mismatches   = 0;
    int        send_gap_pct = 0;
    int        recv_gap_pct = 0;
    bit        hold_req     = 1'b0;
    int        cycles       = 0;

    function automatic int sat_count(input int x);
        return (x > COUNT_MAX) ? COUNT_MAX : x;
    endfunction

    function automatic void close_string(input logic [1:0] status);
        stop_status = status;
        utf8_expect_q.push_back('{8'h00, 1'(wr_count < capacity), 1'b1, status,
                                  16'(rd_count), 16'(wr_count)});
    endfunction

    function automatic void transcode_item(input logic f, input logic [7:0] c);
        logic [23:0] enc;
        int          n;
        int          need;
        if (stop_status != w2u_pkg::ST_RUN)
            return;
        if (f == w2u_pkg::FUNC_END) begin
            close_string(w2u_pkg::ST_EOI);
            return;
        end
        if (c == 8'h00) begin
            close_string(w2u_pkg::ST_NUL);
            return;
        end
        if (c >= 8'hC0) begin
            enc  = {w2u_pkg::LEAD_C3, w2u_pkg::CONT_BASE | (c & w2u_pkg::CONT_MASK), 8'h00};
            n    = 2;
            need = 2;
        end else if (c >= 8'hA0) begin
            enc  = {w2u_pkg::LEAD_C2, w2u_pkg::CONT_BASE | (c & w2u_pkg::CONT_MASK), 8'h00};
            n    = 2;
            need = 2;
        end else if (c >= 8'h80) begin
            // room check always reserves three bytes for this block
            enc  = CP1252_CTL[c[4:0]][23:0];
            n    = int'(CP1252_CTL[c[4:0]][25:24]);
            need = 3;
        end else begin
            enc  = {c, 16'h0000};
            n    = 1;
            need = 1;
        end
        if (wr_count + need >= capacity) begin
            close_string(w2u_pkg::ST_FULL);
            return;
        end
        wr_count = sat_count(wr_count + n);
        rd_count = sat_count(rd_count + 1);
        for (int i = 0; i < n; i++)
            utf8_expect_q.push_back('{enc[23 - 8 * i -: 8], 1'b1, 1'(i == n - 1),
                                      w2u_pkg::ST_RUN, 16'(rd_count), 16'(wr_count)});
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(8'h01, 8'h7F));
            4, 5, 6:    return 8'($urandom_range(8'h80, 8'h9F));
            default:    return 8'($urandom_range(8'hA0, 8'hFF));
        endcase
    endfunction

    // called just after a falling edge; returns just after a falling edge
    task automatic offer_item(input logic f, input logic [7:0] b,
                              input logic [1:0] n_typed = 2'd0,
                              input logic [23:0] typed = 24'h0);
        int        base;
        t_utf8_res r;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.func    <= f;
        in_ch.in_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        base = utf8_expect_q.size();
        transcode_item(f, b);
        for (int i = 0; i < n_typed && base + i < utf8_expect_q.size(); i++) begin
            r = utf8_expect_q[base + i];
            r.out_byte = typed[23 - 8 * i -: 8];
            utf8_expect_q[base + i] = r;
        end
        @(negedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        capacity = int'(v);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (utf8_expect_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_random(input int items);
        repeat (items) offer_item(w2u_pkg::FUNC_DATA, pick_char());
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    always @(posedge clk) begin : result_check
        t_utf8_res want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (utf8_expect_q.size() == 0) begin
                $display("%0t: unexpected transaction: expected none, actual byte %0h",
                         $time, out_ch.out_byte);
                mismatches++;
            end else begin
                want = utf8_expect_q.pop_front();
                check_field("out_byte", 16'(want.out_byte), 16'(out_ch.out_byte));
                check_field("byte_valid", 16'(want.byte_valid), 16'(out_ch.byte_valid));
                check_field("last", 16'(want.last), 16'(out_ch.last));
                check_field("status", 16'(want.status), 16'(out_ch.status));
                check_field("consumed_count", want.consumed, out_ch.consumed_count);
                check_field("written_count", want.written, out_ch.written_count);
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        logic [15:0] end_cap;
        int          pick;
        in_ch.valid   = 1'b0;
        in_ch.func    = w2u_pkg::FUNC_DATA;
        in_ch.in_byte = 8'h00;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = 16'h0000;
        rst_n         = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_gap_pct = 12;
        recv_gap_pct = 86;
        foreach (directed_rows[i])
            offer_item(directed_rows[i].func, directed_rows[i].in_byte,
                       directed_rows[i].n_typed, directed_rows[i].typed);
        drain_results();

        write_capacity(16'hFFFF);
        run_random(125);
        drain_results();

        write_capacity(16'($urandom_range(wr_count + 2000, 16'hFFFF)));
        send_gap_pct = 86;
        recv_gap_pct = 12;
        run_random(125);
        drain_results();

        // no idling; the long receiver hold-off backs the block up into its input
        write_capacity(16'($urandom_range(wr_count + 2000, 16'hFFFF)));
        send_gap_pct = 0;
        recv_gap_pct = 0;
        run_random(30);
        hold_req = 1'b1;
        run_random(95);
        drain_results();

        // one reset per run, so the string ends once: pick how it ends
        case ($urandom_range(0, 3))
            0:       end_cap = 16'h0000;
            1:       end_cap = 16'($urandom_range(0, wr_count));
            2:       end_cap = 16'(wr_count + $urandom_range(1, 8));
            default: end_cap = 16'hFFFF;
        endcase
        write_capacity(end_cap);
        send_gap_pct = 12;
        recv_gap_pct = 12;
        while (stop_status == w2u_pkg::ST_RUN) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                offer_item(w2u_pkg::FUNC_DATA, 8'h00);
            else if (pick == 1)
                offer_item(w2u_pkg::FUNC_END, 8'($urandom));
            else
                offer_item(w2u_pkg::FUNC_DATA, pick_char());
        end
        // after the stop everything is dropped without a result
        repeat (8) offer_item(1'($urandom), 8'($urandom_range(0, 255)));
        drain_results();
        repeat (16) @(negedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/w2u_pkg.sv
rtl/w2u_intf.sv
rtl/w2u_in_reg.sv
rtl/w2u_xlate.sv
rtl/w2u_emit.sv
rtl/win1252_to_utf8_encoder.sv
sim/win1252_to_utf8_encoder_test.sv
